>>> rtl/pexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_pkg
// shared types and constants for the palette expand and nearest match block
// ----------------------------------------------------------------------------
package pexp_pkg;

	localparam int IDX_W   = 8;
	localparam int CH_W    = 8;
	localparam int RGB_W   = 3 * CH_W;
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 18;
	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int SQ_W    = 2 * CH_W;
	// sum of three squares, 3 * 255^2 fits with room to spare
	localparam int DIST_W  = SQ_W + 2;

	localparam logic [CH_W-1:0] ALPHA = 8'hFF;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_CONVERT = 2'd1,
		ACT_SEARCH  = 2'd2
	} action_t;

	typedef struct packed {
		action_t           kind;
		logic [IDX_W-1:0]  idx;
		logic              idx_ok;
		logic [RGB_W-1:0]  rgb;
		logic [ADDR_W-1:0] base;
	} work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV_WAIT,
		ST_CONV_EMIT,
		ST_SRCH_WALK,
		ST_SRCH_READ,
		ST_SRCH_WAIT,
		ST_SRCH_EMIT
	} back_state_t;

endpackage

>>> rtl/pexp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module pexp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/pexp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_front
// accepts input beats, drops no-op beats, clamps coordinates, forms base address
// ----------------------------------------------------------------------------
module pexp_front #(
	parameter int SRC_WIDTH       = 320,
	parameter int SRC_HEIGHT      = 200,
	parameter int DST_STRIDE      = 640,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 action,
	input  logic [pexp_pkg::IDX_W-1:0] entry_index,
	input  logic [pexp_pkg::CH_W-1:0]  red,
	input  logic [pexp_pkg::CH_W-1:0]  green,
	input  logic [pexp_pkg::CH_W-1:0]  blue,
	input  logic [pexp_pkg::X_W-1:0]   pixel_x,
	input  logic [pexp_pkg::Y_W-1:0]   pixel_y,
	input  logic                       q_full,
	output logic                       push,
	output pexp_pkg::work_t            push_data
);

	localparam int AW = pexp_pkg::ADDR_W;
	localparam logic [AW-1:0] X_MAX  = AW'(SRC_WIDTH - 1);
	localparam logic [AW-1:0] Y_MAX  = AW'(SRC_HEIGHT - 1);
	localparam logic [AW-1:0] STRIDE = AW'(DST_STRIDE);
	localparam logic [pexp_pkg::IDX_W:0] N_ENT = (pexp_pkg::IDX_W + 1)'(PALETTE_ENTRIES);

	logic [AW-1:0] x_ext, y_ext, x_sat, y_sat, row, col, row_off;
	logic          idx_ok, keep;
	logic          accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign idx_ok = {1'b0, entry_index} < N_ENT;

	// address arithmetic is modulo 2^ADDR_W throughout
	assign x_ext   = AW'(pixel_x);
	assign y_ext   = AW'(pixel_y);
	assign x_sat   = (x_ext > X_MAX) ? X_MAX : x_ext;
	assign y_sat   = (y_ext > Y_MAX) ? Y_MAX : y_ext;
	assign row     = {y_sat[AW-2:0], 1'b0};
	assign col     = {x_sat[AW-2:0], 1'b0};
	assign row_off = row * STRIDE;

	always_comb begin
		case (action)
			pexp_pkg::ACT_LOAD:    keep = idx_ok;
			pexp_pkg::ACT_CONVERT: keep = 1'b1;
			pexp_pkg::ACT_SEARCH:  keep = 1'b1;
			default:               keep = 1'b0;
		endcase
	end

	assign push             = accept && keep;
	assign push_data.kind   = pexp_pkg::action_t'(action);
	assign push_data.idx    = entry_index;
	assign push_data.idx_ok = idx_ok;
	assign push_data.rgb    = {red, green, blue};
	assign push_data.base   = row_off + col;

endmodule

>>> rtl/pexp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_queue
// short work queue between front and back
// ----------------------------------------------------------------------------
module pexp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pexp_pkg::work_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output pexp_pkg::work_t head
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	pexp_pkg::work_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/pexp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_back
// executes queued work: palette writes, 2x2 expansion beats, nearest search
// ----------------------------------------------------------------------------
module pexp_back #(
	parameter int DST_STRIDE      = 640,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  pexp_pkg::work_t              q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pexp_pkg::COLOR_W-1:0] out_color,
	output logic [pexp_pkg::ADDR_W-1:0]  out_address,
	output logic [pexp_pkg::IDX_W-1:0]   found_index,
	output logic                         last
);

	localparam int AW  = $clog2(PALETTE_ENTRIES);
	localparam int CNW = $clog2(PALETTE_ENTRIES + 1);
	localparam int ADW = pexp_pkg::ADDR_W;
	localparam int CW  = pexp_pkg::CH_W;
	localparam int SW  = pexp_pkg::SQ_W;
	localparam int DW  = pexp_pkg::DIST_W;
	localparam int IW  = pexp_pkg::IDX_W;
	localparam logic [ADW-1:0] STRIDE = ADW'(DST_STRIDE);
	localparam logic [CNW-1:0] N_ENT  = CNW'(PALETTE_ENTRIES);

	pexp_pkg::back_state_t state_q, state_d;

	// palette memory
	logic                      wr_en, rd_en;
	logic [AW-1:0]             rd_addr;
	logic [pexp_pkg::RGB_W-1:0] rd_data;

	// current work
	logic [ADW-1:0]             base_q;
	logic                       idx_ok_q;
	logic [pexp_pkg::RGB_W-1:0] rgb_q;
	logic [pexp_pkg::RGB_W-1:0] color_q;
	logic [1:0]                 beat_q;

	// search walk
	logic [CNW-1:0] rd_cnt_q;
	logic           v_s1, v_s2;
	logic [AW-1:0]  idx_s1, idx_s2;
	logic [SW-1:0]  sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DW-1:0]  best_dist_q, cand_dist;
	logic [AW-1:0]  best_q;
	logic           issue, walk_done;

	// output register
	logic                         out_valid_q;
	logic                         out_free, emit, take, beat_done;
	logic [pexp_pkg::RGB_W-1:0]   emit_rgb;
	logic [ADW-1:0]               emit_addr;
	logic [IW-1:0]                emit_found;
	logic                         emit_last;

	function automatic pexp_pkg::back_state_t dispatch(input pexp_pkg::action_t kind);
		case (kind)
			pexp_pkg::ACT_CONVERT: dispatch = pexp_pkg::ST_CONV_WAIT;
			pexp_pkg::ACT_SEARCH:  dispatch = pexp_pkg::ST_SRCH_WALK;
			default:               dispatch = pexp_pkg::ST_IDLE;
		endcase
	endfunction

	function automatic logic [SW-1:0] sq_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW-1:0] d;
		d = (a >= b) ? a - b : b - a;
		sq_diff = SW'(d) * SW'(d);
	endfunction

	pexp_ram #(
		.WIDTH (pexp_pkg::RGB_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (q_head.idx[AW-1:0]),
		.wr_data (q_head.rgb),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign beat_done = (state_q == pexp_pkg::ST_CONV_EMIT) && out_free && (beat_q == 2'd3);
	assign take      = q_valid && ((state_q == pexp_pkg::ST_IDLE) || beat_done);
	assign issue     = rd_cnt_q != N_ENT;
	assign walk_done = !issue && !v_s1 && !v_s2;
	assign cand_dist = DW'(sq_r_s2) + DW'(sq_g_s2) + DW'(sq_b_s2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pexp_pkg::ST_IDLE: begin
				if (take) begin
					state_d = dispatch(q_head.kind);
				end
			end
			pexp_pkg::ST_CONV_WAIT: state_d = pexp_pkg::ST_CONV_EMIT;
			pexp_pkg::ST_CONV_EMIT: begin
				if (beat_done) begin
					state_d = take ? dispatch(q_head.kind) : pexp_pkg::ST_IDLE;
				end
			end
			pexp_pkg::ST_SRCH_WALK: begin
				if (walk_done) begin
					state_d = pexp_pkg::ST_SRCH_READ;
				end
			end
			pexp_pkg::ST_SRCH_READ: state_d = pexp_pkg::ST_SRCH_WAIT;
			pexp_pkg::ST_SRCH_WAIT: state_d = pexp_pkg::ST_SRCH_EMIT;
			pexp_pkg::ST_SRCH_EMIT: begin
				if (out_free) begin
					state_d = pexp_pkg::ST_IDLE;
				end
			end
			default: state_d = pexp_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop      = take;
		wr_en      = take && (q_head.kind == pexp_pkg::ACT_LOAD);
		rd_en      = 1'b0;
		rd_addr    = q_head.idx[AW-1:0];
		emit       = 1'b0;
		emit_rgb   = color_q;
		emit_addr  = base_q + (beat_q[1] ? STRIDE : '0) + ADW'(beat_q[0]);
		emit_found = '0;
		emit_last  = beat_q == 2'd3;
		if (take && (q_head.kind == pexp_pkg::ACT_CONVERT)) begin
			rd_en = q_head.idx_ok;
		end
		case (state_q)
			pexp_pkg::ST_CONV_WAIT: begin
				// first beat goes straight from the memory output
				emit      = out_free;
				emit_rgb  = idx_ok_q ? rd_data : '0;
				emit_addr = base_q;
				emit_last = 1'b0;
			end
			pexp_pkg::ST_CONV_EMIT: emit = out_free;
			pexp_pkg::ST_SRCH_WALK: begin
				rd_en   = issue;
				rd_addr = rd_cnt_q[AW-1:0];
			end
			pexp_pkg::ST_SRCH_READ: begin
				rd_en   = 1'b1;
				rd_addr = best_q;
			end
			pexp_pkg::ST_SRCH_EMIT: begin
				emit       = out_free;
				emit_addr  = '0;
				emit_found = IW'(best_q);
				emit_last  = 1'b1;
			end
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			base_q   <= q_head.base;
			idx_ok_q <= q_head.idx_ok;
			rgb_q    <= q_head.rgb;
		end
		if (state_q == pexp_pkg::ST_CONV_WAIT) begin
			color_q <= idx_ok_q ? rd_data : '0;
		end
		if (state_q == pexp_pkg::ST_SRCH_WAIT) begin
			color_q <= rd_data;
		end
		idx_s1 <= rd_cnt_q[AW-1:0];
		if (v_s1) begin
			sq_r_s2 <= sq_diff(rgb_q[3*CW-1:2*CW], rd_data[3*CW-1:2*CW]);
			sq_g_s2 <= sq_diff(rgb_q[2*CW-1:CW], rd_data[2*CW-1:CW]);
			sq_b_s2 <= sq_diff(rgb_q[CW-1:0], rd_data[CW-1:0]);
			idx_s2  <= idx_s1;
		end
		// all ones beats any real distance, so entry 0 always lands first
		if (take) begin
			best_dist_q <= '1;
			best_q      <= '0;
		end else if (v_s2 && (cand_dist < best_dist_q)) begin
			best_dist_q <= cand_dist;
			best_q      <= idx_s2;
		end
		if (emit) begin
			out_color   <= {pexp_pkg::ALPHA, emit_rgb};
			out_address <= emit_addr;
			found_index <= emit_found;
			last        <= emit_last;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pexp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			beat_q      <= '0;
			rd_cnt_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == pexp_pkg::ST_CONV_WAIT) begin
				beat_q <= out_free ? 2'd1 : 2'd0;
			end else if ((state_q == pexp_pkg::ST_CONV_EMIT) && out_free) begin
				beat_q <= beat_q + 2'd1;
			end
			if (take) begin
				rd_cnt_q <= '0;
			end else if ((state_q == pexp_pkg::ST_SRCH_WALK) && issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1 <= (state_q == pexp_pkg::ST_SRCH_WALK) && issue;
			v_s2 <= v_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/palette_expand_and_nearest_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_expand_and_nearest_match
// indexed color palette with 2x2 pixel expansion and nearest color search
// ----------------------------------------------------------------------------
//
// channel   dir  handshake           payload
// input     in   in_valid/in_stall   action, entry_index, red, green, blue,
//                                    pixel_x, pixel_y
// output    out  out_valid/out_stall out_color, out_address, found_index, last
//
// a load gives no beat
// a convert gives four output beats; its palette read overlaps
//   the last beat of the convert before it
// a search walks all PALETTE_ENTRIES through the single palette read port,
//   one entry per cycle
// reset clears control state only; the palette holds nothing until loaded
// a two-entry queue lets the input side keep taking beats while results stall, until it fills
//
module palette_expand_and_nearest_match #(
	parameter int SRC_WIDTH       = 320,
	parameter int SRC_HEIGHT      = 200,
	parameter int DST_STRIDE      = 640,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input beats
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [pexp_pkg::IDX_W-1:0]   entry_index,
	input  logic [pexp_pkg::CH_W-1:0]    red,
	input  logic [pexp_pkg::CH_W-1:0]    green,
	input  logic [pexp_pkg::CH_W-1:0]    blue,
	input  logic [pexp_pkg::X_W-1:0]     pixel_x,
	input  logic [pexp_pkg::Y_W-1:0]     pixel_y,
	// result beats
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pexp_pkg::COLOR_W-1:0] out_color,
	output logic [pexp_pkg::ADDR_W-1:0]  out_address,
	output logic [pexp_pkg::IDX_W-1:0]   found_index,
	output logic                         last
);

	// front to queue
	logic            push, q_full;
	pexp_pkg::work_t push_data;

	// queue to back
	logic            pop, q_valid;
	pexp_pkg::work_t q_head;

	// front: classify, drop no-op beats, clamp coordinates, form base address
	pexp_front #(
		.SRC_WIDTH       (SRC_WIDTH),
		.SRC_HEIGHT      (SRC_HEIGHT),
		.DST_STRIDE      (DST_STRIDE),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	// decoupling queue, keeps work in arrival order so loads and reads never reorder
	pexp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// back: owns the palette memory and the output register
	pexp_back #(
		.DST_STRIDE      (DST_STRIDE),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_color   (out_color),
		.out_address (out_address),
		.found_index (found_index),
		.last        (last)
	);

endmodule
